// ===== src/frm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package frm_pkg;

	// Rule table geometry
	localparam int RULE_DEPTH = 64;
	localparam int RULE_AW    = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
	localparam int CNT_W      = $clog2(RULE_DEPTH + 1);

	// Request queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	localparam logic [9:0] PORT_CLAMP = 10'd1023;
	localparam logic [5:0] LEN_MAX    = 6'd32;

	// Request kinds
	localparam logic KIND_WRITE    = 1'b0;
	localparam logic KIND_CLASSIFY = 1'b1;

	// Protocol codes
	localparam logic [2:0] PROTO_ICMP  = 3'd0;
	localparam logic [2:0] PROTO_TCP   = 3'd1;
	localparam logic [2:0] PROTO_UDP   = 3'd2;
	localparam logic [2:0] PROTO_OTHER = 3'd3;
	localparam logic [2:0] PROTO_ANY   = 3'd4;

	localparam logic [7:0] IPPROTO_ICMP = 8'd1;
	localparam logic [7:0] IPPROTO_TCP  = 8'd6;
	localparam logic [7:0] IPPROTO_UDP  = 8'd17;

	// Ack codes
	localparam logic [1:0] ACK_NO  = 2'd0;
	localparam logic [1:0] ACK_YES = 2'd1;
	localparam logic [1:0] ACK_ANY = 2'd2;

	localparam logic VERDICT_DROP   = 1'b0;
	localparam logic VERDICT_ACCEPT = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [5:0]  rule_index;
		logic [2:0]  rule_protocol;
		logic [7:0]  protocol;
		logic [31:0] src_addr;
		logic [5:0]  src_prefix_len;
		logic [31:0] dst_addr;
		logic [5:0]  dst_prefix_len;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [1:0]  ack_code;
		logic        verdict_in;
	} in_item_t;

	typedef struct packed {
		logic       verdict;
		logic       matched;
		logic [5:0] matched_index;
	} out_item_t;

	// One rule as held in the table; a classified packet uses the same layout
	typedef struct packed {
		logic [2:0]  proto;
		logic [31:0] src_addr;
		logic [5:0]  src_len;
		logic [31:0] dst_addr;
		logic [5:0]  dst_len;
		logic [9:0]  sport;
		logic [9:0]  dport;
		logic [1:0]  ack;
		logic        verdict;
	} rule_t;

	typedef struct packed {
		logic       is_pkt;
		logic [5:0] index;
		rule_t      body;
	} q_item_t;

	function automatic logic [9:0] clamp_port(input logic [15:0] p);
		clamp_port = (p > 16'(PORT_CLAMP)) ? PORT_CLAMP : p[9:0];
	endfunction

	function automatic logic [5:0] sat_len(input logic [5:0] len);
		sat_len = (len > LEN_MAX) ? LEN_MAX : len;
	endfunction

endpackage

`default_nettype wire

// ===== src/firewall_rule_matcher_top.sv =====
// Each request is registered in the front stage and queued while the queue has room; the
// back end pops one only when idle. A classify walks the rule table from index 0 below
// rule_count, reading one rule per cycle from its registered read port; the first match
// wins, no match or an empty table gives default accept; rule writes land when popped.
// Reset clears control state and rule_count; table contents stay undefined until
// written, with no clearing pass. Results are one-cycle strobes that cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module firewall_rule_matcher_top (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  frm_pkg::in_item_t  request,
	output logic               done,
	output frm_pkg::out_item_t result,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [6:0]         cfg_data
);
	import frm_pkg::*;

	logic    push;
	q_item_t push_data;
	logic    q_full;
	logic    q_empty;
	logic    pop;
	q_item_t pop_data;

	assign cfg_ready = 1'b1;

	frm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.q_full    (q_full),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	frm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.pop_data  (pop_data)
	);

	frm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (pop_data),
		.pop      (pop),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.done     (done),
		.result   (result)
	);

endmodule

`default_nettype wire

// ===== src/frm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module frm_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  frm_pkg::in_item_t request,
	input  wire               q_full,
	output logic              busy,
	output logic              push,
	output frm_pkg::q_item_t  push_data
);
	import frm_pkg::*;

	logic    vld_s1;
	q_item_t ent_s1;
	q_item_t ent_d;
	logic    accept;
	logic    tcp_udp;

	// Classify the request into a queue entry
	always_comb begin
		ent_d        = '0;
		ent_d.index  = request.rule_index;
		tcp_udp      = 1'b0;
		if (request.kind == KIND_WRITE) begin
			ent_d.is_pkt        = 1'b0;
			ent_d.body.proto    = request.rule_protocol;
			ent_d.body.src_addr = request.src_addr;
			ent_d.body.src_len  = sat_len(request.src_prefix_len);
			ent_d.body.dst_addr = request.dst_addr;
			ent_d.body.dst_len  = sat_len(request.dst_prefix_len);
			ent_d.body.sport    = clamp_port(request.sport);
			ent_d.body.dport    = clamp_port(request.dport);
			ent_d.body.ack      = request.ack_code;
			ent_d.body.verdict  = request.verdict_in;
		end else begin
			ent_d.is_pkt = 1'b1;
			case (request.protocol)
				IPPROTO_ICMP: ent_d.body.proto = PROTO_ICMP;
				IPPROTO_TCP:  ent_d.body.proto = PROTO_TCP;
				IPPROTO_UDP:  ent_d.body.proto = PROTO_UDP;
				default:      ent_d.body.proto = PROTO_OTHER;
			endcase
			tcp_udp = (ent_d.body.proto == PROTO_TCP) || (ent_d.body.proto == PROTO_UDP);
			ent_d.body.src_addr = request.src_addr;
			ent_d.body.dst_addr = request.dst_addr;
			if (tcp_udp) begin
				ent_d.body.sport = clamp_port(request.sport);
				ent_d.body.dport = clamp_port(request.dport);
			end
			if (ent_d.body.proto == PROTO_TCP) begin
				ent_d.body.ack = (request.ack_code != 2'd0) ? ACK_YES : ACK_NO;
			end else begin
				ent_d.body.ack = ACK_ANY;
			end
		end
	end

	assign busy   = vld_s1 && q_full;
	assign push   = vld_s1 && !q_full;
	assign accept = start && !busy;
	assign push_data = ent_s1;

	// Hold the registered queue entry, write or classify, until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_s1 <= ent_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/frm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module frm_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  frm_pkg::q_item_t push_data,
	input  wire              pop,
	output logic             full,
	output logic             empty,
	output frm_pkg::q_item_t pop_data
);
	import frm_pkg::*;

	q_item_t          slot_q [Q_DEPTH];
	logic [Q_PW-1:0]  wr_ptr_q;
	logic [Q_PW-1:0]  rd_ptr_q;
	logic [Q_PW:0]    fill_q;

	assign full     = (fill_q == (Q_PW + 1)'(Q_DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/frm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module frm_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               q_empty,
	input  frm_pkg::q_item_t  q_data,
	output logic              pop,
	input  wire               cfg_we,
	input  wire  [6:0]        cfg_data,
	output logic              done,
	output frm_pkg::out_item_t result
);
	import frm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   ptr_q;
	rule_t              pkt_q;
	logic               done_q;
	out_item_t          result_q;

	rule_t              mem [RULE_DEPTH];
	rule_t              rd_s1;
	logic               rd_vld_s1;
	logic [RULE_AW-1:0] idx_s1;

	logic               wr_en;
	logic [RULE_AW-1:0] wr_addr;
	logic               hit;
	logic               last_s1;
	logic [31:0]        src_mask;
	logic [31:0]        dst_mask;
	logic               src_ok;
	logic               dst_ok;

	assign pop     = (state_q == ST_IDLE) && !q_empty;
	assign wr_en   = pop && !q_data.is_pkt && (int'(q_data.index) < RULE_DEPTH);
	assign wr_addr = RULE_AW'(q_data.index);

	// Compare the fetched rule against the held packet
	always_comb begin
		src_mask = ~(32'hFFFF_FFFF >> rd_s1.src_len);
		dst_mask = ~(32'hFFFF_FFFF >> rd_s1.dst_len);
		src_ok   = (rd_s1.src_addr == '0) ||
			((rd_s1.src_addr & src_mask) == (pkt_q.src_addr & src_mask));
		dst_ok   = (rd_s1.dst_addr == '0) ||
			((rd_s1.dst_addr & dst_mask) == (pkt_q.dst_addr & dst_mask));
		hit = ((rd_s1.proto == PROTO_ANY) || (rd_s1.proto == pkt_q.proto)) &&
			src_ok && dst_ok &&
			((rd_s1.sport == '0) || (rd_s1.sport == pkt_q.sport)) &&
			((rd_s1.dport == '0) || (rd_s1.dport == pkt_q.dport)) &&
			((rd_s1.ack == ACK_ANY) || (rd_s1.ack == pkt_q.ack));
	end

	assign last_s1 = ((CNT_W'(idx_s1) + 1'b1) == count_q);

	// Rule table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= q_data.body;
		end
		rd_s1 <= mem[ptr_q[RULE_AW-1:0]];
	end

	// Hold the packet and the fetch index
	always_ff @(posedge clk) begin
		if (pop && q_data.is_pkt) begin
			pkt_q <= q_data.body;
		end
		if (state_q == ST_WALK) begin
			idx_s1 <= ptr_q[RULE_AW-1:0];
		end
	end

	// Sequence the first-match walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
			result_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				count_q <= (int'(cfg_data) > RULE_DEPTH) ? CNT_W'(RULE_DEPTH) : CNT_W'(cfg_data);
			end
			case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					ptr_q     <= '0;
					if (pop && q_data.is_pkt) begin
						if (count_q == '0) begin
							done_q   <= 1'b1;
							result_q <= '{verdict: VERDICT_ACCEPT, matched: 1'b0,
								matched_index: 6'd0};
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (ptr_q < count_q) begin
						ptr_q     <= ptr_q + 1'b1;
						rd_vld_s1 <= 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (rd_vld_s1) begin
						if (hit) begin
							done_q    <= 1'b1;
							result_q  <= '{verdict: rd_s1.verdict, matched: 1'b1,
								matched_index: 6'(idx_s1)};
							state_q   <= ST_IDLE;
							rd_vld_s1 <= 1'b0;
						end else if (last_s1) begin
							done_q    <= 1'b1;
							result_q  <= '{verdict: VERDICT_ACCEPT, matched: 1'b0,
								matched_index: 6'd0};
							state_q   <= ST_IDLE;
							rd_vld_s1 <= 1'b0;
						end
					end
				end
				default: begin
					state_q   <= ST_IDLE;
					rd_vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== src/frm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module frm_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                start,
	input wire                busy,
	input frm_pkg::in_item_t  request,
	input wire                done,
	input frm_pkg::out_item_t result,
	input wire                cfg_valid,
	input wire                cfg_ready
);
	import frm_pkg::*;

	logic [3:0] pending_q;
	logic       take_pkt;

	assign take_pkt = start && !busy && (request.kind == KIND_CLASSIFY);

	// Track classify requests still owed a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {3'd0, take_pkt} - {3'd0, done};
		end
	end

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pending_q != 4'd0))
		else $error("result without an outstanding classify request");

	a_pending_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'd4)
		else $error("more classify requests in flight than stages hold");

	a_default_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.matched) |->
			(result.verdict == VERDICT_ACCEPT) && (result.matched_index == 6'd0))
		else $error("unmatched packet not given default accept");

	a_cfg_not_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind firewall_rule_matcher_top frm_checker u_frm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.request   (request),
	.done      (done),
	.result    (result),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire
